@@ hw/rtl/integer_to_radix_symbols_top_macros.svh @@
// ---------------------------------------------------------------------------
// integer_to_radix_symbols_top_macros
// assertion helpers shared by the checker of the radix symbol converter
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_SYMBOLS_TOP_MACROS_SVH
`define INTEGER_TO_RADIX_SYMBOLS_TOP_MACROS_SVH

// next-cycle implication, quiet while reset is high
`define INT2RS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("int2rs assertion failed");

// same-cycle implication, quiet while reset is high
`define INT2RS_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("int2rs assertion failed");

// state in the cycle after reset was seen
`define INT2RS_ASSERT_AFTER_RESET(lbl, clk, rst, post) \
   lbl: assert property (@(posedge clk) (rst) |=> (post)) \
      else $error("int2rs reset assertion failed");

`endif

@@ hw/rtl/int2rs_pkg.sv @@
// ---------------------------------------------------------------------------
// int2rs_pkg
// shared types and constants of the radix symbol converter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package int2rs_pkg;

   localparam int SYMBOL_W       = 8;
   localparam int RADIX_W        = 6;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 64;
   localparam int SYMBOL_WORDS   = 4;
   localparam int ALPHABET_W     = SYMBOL_WORDS * CSR_DATA_W;
   localparam int SYMBOL_INDEX_W = 5;
   localparam int DIV_STEP_BITS  = 8;

   typedef logic [SYMBOL_W-1:0]    symbol_type;
   typedef logic [RADIX_W-1:0]     radix_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [ALPHABET_W-1:0]  alphabet_type;

   localparam symbol_type MINUS_SYMBOL = 8'd45;
   localparam radix_type  RADIX_RESET  = 6'd10;
   localparam radix_type  RADIX_MIN    = 6'd2;

   // register map
   localparam csr_index_type REG_RADIX     = 3'd0;
   localparam csr_index_type REG_SYMBOLS_0 = 3'd1;
   localparam csr_index_type REG_SYMBOLS_1 = 3'd2;
   localparam csr_index_type REG_SYMBOLS_2 = 3'd3;
   localparam csr_index_type REG_SYMBOLS_3 = 3'd4;

endpackage

@@ hw/rtl/integer_to_radix_symbols_top.sv @@
// ---------------------------------------------------------------------------
// integer_to_radix_symbols_top
// conversion: the divider works through the magnitude in 8-bit chunks, each digit
//   goes onto a stack, and emission starts once the last digit is stored
// a new value leaves the queue only after the last symbol of the previous one is
//   loaded into the response register; request beats meanwhile wait in the queue
// reset: synchronous, clears control, radix back to 10, alphabet to zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_radix_symbols_top #(
   parameter int MAX_SYMBOLS = 32,
   parameter int VALUE_BITS  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   // request beats: one signed value each
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   // response beats: one symbol each, last marks the end of a value
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output int2rs_pkg::symbol_type       rsp_symbol,
   output logic                         rsp_last,
   // register writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  int2rs_pkg::csr_index_type    csr_index,
   input  int2rs_pkg::csr_data_type     csr_data
);
   import int2rs_pkg::*;

   localparam int ENTRY_W = 1 + VALUE_BITS + RADIX_W;

   // configuration registers
   radix_type    radix_ff, radix_in;
   csr_data_type symbols_ff [SYMBOL_WORDS];
   csr_data_type symbols_in [SYMBOL_WORDS];
   alphabet_type alphabet;

   // front to queue to back
   logic               queue_push;
   logic [ENTRY_W-1:0] queue_push_data;
   logic               queue_full;
   logic               queue_pop;
   logic               queue_pop_valid;
   logic [ENTRY_W-1:0] queue_pop_data;

   // writes are always taken, indexes past the map are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      radix_in   = radix_ff;
      symbols_in = symbols_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RADIX:     radix_in      = csr_data[RADIX_W-1:0];
            REG_SYMBOLS_0: symbols_in[0] = csr_data;
            REG_SYMBOLS_1: symbols_in[1] = csr_data;
            REG_SYMBOLS_2: symbols_in[2] = csr_data;
            REG_SYMBOLS_3: symbols_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         for (int w = 0; w < SYMBOL_WORDS; w++) begin
            symbols_ff[w] <= '0;
         end
      end else begin
         radix_ff   <= radix_in;
         symbols_ff <= symbols_in;
      end
   end

   // symbol 0 sits in the low byte of the flat alphabet
   assign alphabet = {symbols_ff[3], symbols_ff[2], symbols_ff[1], symbols_ff[0]};

   // front: sign and magnitude split, radix clamped to 2..MAX_SYMBOLS
   int2rs_front #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .radix      (radix_ff),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (queue_push_data)
   );

   // short queue so a new beat lands while the back end is converting
   int2rs_fifo #(
      .WIDTH (ENTRY_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_pop_valid),
      .pop_data  (queue_pop_data)
   );

   // back: digits least significant first onto a stack, emitted from the top
   int2rs_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_pop_valid),
      .item_data  (queue_pop_data),
      .item_pop   (queue_pop),
      .alphabet   (alphabet),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule

@@ hw/rtl/int2rs_front.sv @@
// ---------------------------------------------------------------------------
// int2rs_front
// takes request beats, splits sign and magnitude, clamps the radix
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module int2rs_front #(
   parameter int MAX_SYMBOLS = 32,
   parameter int VALUE_BITS  = 32
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  int2rs_pkg::radix_type        radix,
   input  logic                         queue_full,
   output logic                         queue_push,
   output logic [VALUE_BITS+int2rs_pkg::RADIX_W:0] queue_data
);
   import int2rs_pkg::*;

   localparam radix_type RADIX_MAX = RADIX_W'(MAX_SYMBOLS);

   logic                  neg;
   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] mag;
   radix_type             base;

   assign raw  = req_value;
   assign neg  = raw[VALUE_BITS-1];
   // most negative value maps to 2^(n-1), which still fits unsigned
   assign mag  = neg ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

   always_comb begin
      if (radix < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         base = RADIX_MAX;
      end else begin
         base = radix;
      end
   end

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;
   assign queue_data = {neg, mag, base};

endmodule

@@ hw/rtl/int2rs_fifo.sv @@
// ---------------------------------------------------------------------------
// int2rs_fifo
// two-entry queue between the front and the converter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module int2rs_fifo #(
   parameter int WIDTH = 39
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH   = 2;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + COUNT_W'(1);
         2'b01:   count_in = count_ff - COUNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/int2rs_back.sv @@
// ---------------------------------------------------------------------------
// int2rs_back
// digit extraction by repeated division, digit stack and response register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module int2rs_back #(
   parameter int MAX_SYMBOLS = 32,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    item_valid,
   input  logic [VALUE_BITS+int2rs_pkg::RADIX_W:0] item_data,
   output logic                                    item_pop,
   input  int2rs_pkg::alphabet_type                alphabet,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output int2rs_pkg::symbol_type                  rsp_symbol,
   output logic                                    rsp_last
);
   import int2rs_pkg::*;

   localparam int CHUNKS  = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int WORK_W  = CHUNKS * DIV_STEP_BITS;
   localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int DIGIT_W = $clog2(MAX_SYMBOLS);
   localparam int SP_W    = $clog2(VALUE_BITS + 1);
   localparam int IDX_W   = $clog2(VALUE_BITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [WORK_W-1:0]      work_ff, work_in;
   radix_type              rem_ff, rem_in;
   logic [CHUNK_W-1:0]     chunk_ff, chunk_in;
   radix_type              base_ff, base_in;
   logic                   neg_ff, neg_in;
   logic [SP_W-1:0]        sp_ff, sp_in;
   logic [DIGIT_W-1:0]     stack_ff [VALUE_BITS];
   logic                   rsp_valid_ff, rsp_valid_in;
   symbol_type             rsp_symbol_ff, rsp_symbol_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   stack_we;
   logic [DIGIT_W-1:0]     digit_in;
   radix_type              step_rem;
   radix_type              trial;
   logic [DIV_STEP_BITS-1:0] step_quo;
   logic [WORK_W-1:0]      work_shift;
   logic                   last_chunk;
   logic                   load_ok;
   logic [SP_W-1:0]        sp_dec;
   logic [IDX_W-1:0]       top_idx;
   logic [SYMBOL_INDEX_W-1:0] sym_idx;
   symbol_type             top_symbol;

   // fields of a queue entry
   logic                   item_neg;
   logic [VALUE_BITS-1:0]  item_mag;
   radix_type              item_base;

   assign {item_neg, item_mag, item_base} = item_data;

   // eight restoring division steps per cycle, remainder stays below the radix
   always_comb begin
      step_rem = rem_ff;
      step_quo = '0;
      trial    = '0;
      for (int b = 0; b < DIV_STEP_BITS; b++) begin
         trial = {step_rem[RADIX_W-2:0], work_ff[WORK_W-1-b]};
         if (trial >= base_ff) begin
            step_rem = trial - base_ff;
            step_quo[DIV_STEP_BITS-1-b] = 1'b1;
         end else begin
            step_rem = trial;
         end
      end
   end

   assign work_shift = WORK_W'({work_ff, step_quo});
   assign last_chunk = (chunk_ff == CHUNK_W'(CHUNKS - 1));
   assign digit_in   = step_rem[DIGIT_W-1:0];

   assign sp_dec     = sp_ff - SP_W'(1);
   assign top_idx    = sp_dec[IDX_W-1:0];
   assign sym_idx    = SYMBOL_INDEX_W'(stack_ff[top_idx]);
   assign top_symbol = alphabet[{sym_idx, 3'b000} +: SYMBOL_W];

   assign load_ok    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      rem_in        = rem_ff;
      chunk_in      = chunk_ff;
      base_in       = base_ff;
      neg_in        = neg_ff;
      sp_in         = sp_ff;
      item_pop      = 1'b0;
      stack_we      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               work_in  = WORK_W'(item_mag);
               base_in  = item_base;
               neg_in   = item_neg;
               rem_in   = '0;
               chunk_in = '0;
               sp_in    = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            work_in = work_shift;
            if (last_chunk) begin
               stack_we = 1'b1;
               sp_in    = sp_ff + SP_W'(1);
               rem_in   = '0;
               chunk_in = '0;
               if (work_shift == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end else begin
               rem_in   = step_rem;
               chunk_in = chunk_ff + CHUNK_W'(1);
            end
         end
         ST_SIGN: begin
            if (load_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = MINUS_SYMBOL;
               rsp_last_in   = 1'b0;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = top_symbol;
               rsp_last_in   = (sp_ff == SP_W'(1));
               sp_in         = sp_dec;
               if (sp_ff == SP_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sp_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sp_ff        <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      rem_ff        <= rem_in;
      chunk_ff      <= chunk_in;
      base_ff       <= base_in;
      neg_ff        <= neg_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      if (stack_we) begin
         stack_ff[sp_ff[IDX_W-1:0]] <= digit_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ hw/rtl/int2rs_checker.sv @@
// ---------------------------------------------------------------------------
// int2rs_checker
// port-level checks of the radix symbol converter, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_to_radix_symbols_top_macros.svh"

module int2rs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input int2rs_pkg::symbol_type rsp_symbol,
   input logic                   rsp_last
);

   // set once any request beat went in since reset
   logic seen_ff, seen_in;

   assign seen_in = seen_ff || (req_valid && !req_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   `INT2RS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `INT2RS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_symbol) && $stable(rsp_last))
   `INT2RS_ASSERT_NOW(a_no_spurious_rsp, clock, reset, rsp_valid, seen_ff)
   `INT2RS_ASSERT_AFTER_RESET(a_reset_quiet, clock, reset, !rsp_valid && !req_stall)

endmodule

bind integer_to_radix_symbols_top int2rs_checker u_checker (.*);

@@ sim/integer_to_radix_symbols_top_test.sv @@
// ---------------------------------------------------------------------------
// integer_to_radix_symbols_top_test
// self-checking bench for the radix symbol converter: a directed table of
// register writes and values, then random values under random radix and
// alphabet settings, each symbol beat checked against typed symbols or an in-bench converter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_radix_symbols_top_test;

   import int2rs_pkg::*;

   localparam int MAX_SYMBOLS   = 32;
   localparam int VALUE_BITS    = 32;
   localparam int CYCLE_LIMIT   = 500_000;
   localparam int END_HOLD_OFF  = 200;   // hold-off before the verdict; the longest value has 33 symbols
   localparam int BLOCK_ITEMS   = 17;
   localparam int BLOCKS_PER_PHASE = 2;

   // indexes past the register map, writes there are dropped
   localparam csr_index_type REG_UNMAPPED_LAST = 3'd7;

   // idle percentages per phase: sender, receiver
   localparam int SEND_IDLE_PCT [3] = '{16, 62, 0};
   localparam int RECV_IDLE_PCT [3] = '{62, 16, 0};

   typedef enum logic {ROW_WRITE, ROW_VALUE} row_kind_type;

   // one directed step; typed_count 0 means use the in-bench converter,
   // otherwise typed_symbols holds the symbols, first one in bits 7:0
   typedef struct packed {
      row_kind_type  kind;
      csr_index_type index;
      csr_data_type  data;
      logic [2:0]    typed_count;
      logic [31:0]   typed_symbols;
   } stim_row_type;

   typedef struct packed {
      symbol_type symbol;
      logic       last;
   } symbol_beat_type;

   // readable alphabet: 0-9 then A-V
   localparam csr_data_type DIGITS_0 = 64'h3736_3534_3332_3130;
   localparam csr_data_type DIGITS_1 = 64'h4645_4443_4241_3938;
   localparam csr_data_type DIGITS_2 = 64'h4E4D_4C4B_4A49_4847;
   localparam csr_data_type DIGITS_3 = 64'h5655_5453_5251_504F;

   localparam int DIRECTED_ROWS = 32;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // after reset: radix 10, alphabet all zero
      '{ROW_VALUE, REG_RADIX, 64'h0000_0000, 3'd1, 32'h0000_0000},
      '{ROW_VALUE, REG_RADIX, 64'hFFFF_FFFF, 3'd2, 32'h0000_002D},
      '{ROW_VALUE, REG_RADIX, 64'h7FFF_FFFF, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'h8000_0000, 3'd0, 32'h0},
      // load the alphabet
      '{ROW_WRITE, REG_SYMBOLS_0, DIGITS_0, 3'd0, 32'h0},
      '{ROW_WRITE, REG_SYMBOLS_1, DIGITS_1, 3'd0, 32'h0},
      '{ROW_WRITE, REG_SYMBOLS_2, DIGITS_2, 3'd0, 32'h0},
      '{ROW_WRITE, REG_SYMBOLS_3, DIGITS_3, 3'd0, 32'h0},
      // decimal: "255" and "-42"
      '{ROW_VALUE, REG_RADIX, 64'h0000_00FF, 3'd3, 32'h0035_3532},
      '{ROW_VALUE, REG_RADIX, 64'hFFFF_FFD6, 3'd3, 32'h0032_342D},
      // hex
      '{ROW_WRITE, REG_RADIX, 64'd16, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'hDEAD_BEEF, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'h0000_00FF, 3'd2, 32'h0000_4646},
      // binary, most negative value gives the longest output
      '{ROW_WRITE, REG_RADIX, 64'd2, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'h8000_0000, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'h0000_0005, 3'd3, 32'h0031_3031},
      // full alphabet
      '{ROW_WRITE, REG_RADIX, 64'd32, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'h0000_001F, 3'd1, 32'h0000_0056},
      '{ROW_VALUE, REG_RADIX, 64'h8000_0000, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'h7FFF_FFFF, 3'd0, 32'h0},
      // radix below two acts as binary
      '{ROW_WRITE, REG_RADIX, 64'd0, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'h0000_0006, 3'd3, 32'h0030_3131},
      '{ROW_WRITE, REG_RADIX, 64'd1, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'hFFFF_FFFD, 3'd3, 32'h0031_312D},
      // radix above the alphabet size clamps to 32
      '{ROW_WRITE, REG_RADIX, 64'd33, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'h0000_0020, 3'd2, 32'h0000_3031},
      '{ROW_WRITE, REG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'hFFFF_FFFF, 3'd2, 32'h0000_312D},
      // write past the map must leave everything alone
      '{ROW_WRITE, REG_UNMAPPED_LAST, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'h0000_000A, 3'd1, 32'h0000_0041},
      // only the low six bits of a radix write count
      '{ROW_WRITE, REG_RADIX, 64'hABCD_0000_0000_000A, 3'd0, 32'h0},
      '{ROW_VALUE, REG_RADIX, 64'h4996_02D2, 3'd0, 32'h0}
   };

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   symbol_type                   rsp_symbol;
   logic                         rsp_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   csr_index_type                csr_index = REG_RADIX;
   csr_data_type                 csr_data  = '0;

   // shadow copy of the block's registers
   radix_type    radix_setting = RADIX_RESET;
   alphabet_type alphabet_bits = '0;

   symbol_beat_type pending_symbols [$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              send_idle_pct  = 0;
   int              recv_idle_pct  = 0;

   integer_to_radix_symbols_top #(
      .MAX_SYMBOLS(MAX_SYMBOLS),
      .VALUE_BITS (VALUE_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_symbol(rsp_symbol),
      .rsp_last  (rsp_last),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // expected symbol beats of one value under the current shadow registers
   function automatic void convert_to_symbols(input logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] magnitude;
      int unsigned           base;
      int unsigned           digit_list [VALUE_BITS];
      int                    digit_count;
      base = radix_setting;
      if (base < RADIX_MIN) base = RADIX_MIN;
      if (base > MAX_SYMBOLS) base = MAX_SYMBOLS;
      // negation at full width also covers the most negative value
      magnitude = value[VALUE_BITS-1] ? ('0 - value) : value;
      digit_count = 0;
      do begin
         digit_list[digit_count] = magnitude % base;
         magnitude = magnitude / base;
         digit_count++;
      end while (magnitude != 0);
      if (value[VALUE_BITS-1]) pending_symbols.push_back('{MINUS_SYMBOL, 1'b0});
      for (int i = digit_count - 1; i >= 0; i--) begin
         pending_symbols.push_back('{alphabet_bits[digit_list[i]*SYMBOL_W +: SYMBOL_W],
                                     i == 0});
      end
   endfunction

   // one request beat; valid stays high until the next call idles or a drain drops it
   task automatic send_value(input logic [VALUE_BITS-1:0] value, input int typed_count,
                             input logic [31:0] typed_symbols);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed_count == 0) begin
         convert_to_symbols(value);
      end else begin
         for (int k = 0; k < typed_count; k++) begin
            pending_symbols.push_back('{typed_symbols[k*SYMBOL_W +: SYMBOL_W],
                                        k == typed_count - 1});
         end
      end
   endtask

   // block goes idle once every expected beat is back
   task automatic drain_results;
      req_valid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input csr_data_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == REG_RADIX) begin
         radix_setting = data[RADIX_W-1:0];
      end else if (index >= REG_SYMBOLS_0 && index <= REG_SYMBOLS_3) begin
         alphabet_bits[(index - REG_SYMBOLS_0)*CSR_DATA_W +: CSR_DATA_W] = data;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // new radix, some new alphabet words, now and then a stray write
   task automatic pick_new_setting;
      csr_data_type data;
      data = {$urandom, $urandom};
      case ($urandom_range(11))
         0: data[RADIX_W-1:0] = 6'd0;
         1: data[RADIX_W-1:0] = 6'd1;
         2: data[RADIX_W-1:0] = RADIX_MIN;
         3: data[RADIX_W-1:0] = 6'd32;
         4: data[RADIX_W-1:0] = 6'd33;
         5: data[RADIX_W-1:0] = 6'd63;
         default: data[RADIX_W-1:0] = radix_type'($urandom_range(2, 32));
      endcase
      write_register(REG_RADIX, data);
      for (int w = REG_SYMBOLS_0; w <= REG_SYMBOLS_3; w++) begin
         if ($urandom_range(1) == 0) write_register(csr_index_type'(w), {$urandom, $urandom});
      end
      if ($urandom_range(3) == 0) begin
         write_register(csr_index_type'($urandom_range(REG_SYMBOLS_3 + 1, REG_UNMAPPED_LAST)),
                        {$urandom, $urandom});
      end
   endtask

   // spread of lengths: extremes, short values, shifted values, full random
   function automatic logic [VALUE_BITS-1:0] pick_value;
      logic [VALUE_BITS-1:0] value;
      value = $urandom;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = 32'h0000_0000;
               3: value = 32'hFFFF_FFFF;
               default: value = 32'h0000_0001;
            endcase
         end
         1, 2: value = $urandom_range(600) - 300;
         3, 4: value = $signed(value) >>> $urandom_range(31);
         default: ;
      endcase
      return value;
   endfunction

   // response side: check every accepted beat, then pick the next stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_symbols.size() == 0) begin
               report_mismatch("symbol with nothing pending", rsp_symbol, 0);
            end else begin
               symbol_beat_type want;
               want = pending_symbols.pop_front();
               if (rsp_symbol !== want.symbol) report_mismatch("symbol", rsp_symbol, want.symbol);
               if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table under the first idle mix
      send_idle_pct = SEND_IDLE_PCT[0];
      recv_idle_pct = RECV_IDLE_PCT[0];
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].kind == ROW_WRITE) begin
            drain_results();
            write_register(DIRECTED[r].index, DIRECTED[r].data);
         end else begin
            send_value(DIRECTED[r].data[VALUE_BITS-1:0], DIRECTED[r].typed_count,
                       DIRECTED[r].typed_symbols);
         end
      end

      // random values, fresh setting per block, idle mix per phase
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = SEND_IDLE_PCT[phase];
         recv_idle_pct = RECV_IDLE_PCT[phase];
         for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
            drain_results();
            pick_new_setting();
            for (int n = 0; n < BLOCK_ITEMS; n++) send_value(pick_value(), 0, 32'h0);
         end
      end

      drain_results();
      // catch stray beats after the last expected one
      repeat (END_HOLD_OFF) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
